// ===== src/wtrs_pkg.sv =====
// Shared constants, types and register codes for the wheel target ramp shaper.
// Depends on nothing; used by wheel_target_ramp_shaper.
`timescale 1ns / 1ps
`default_nettype none

package wtrs_pkg;

  // Wheel count and speed width
  localparam int NUM_WHEELS   = 3;
  localparam int SPEED_W      = 24;
  localparam int WHEEL_W      = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  // A wheel entry must be written back before it is read again; this sets the
  // least number of issue slots an item occupies.
  localparam int ISSUE_CYCLES = (NUM_WHEELS > 3) ? NUM_WHEELS : 3;
  localparam int SLOT_W       = $clog2(ISSUE_CYCLES);

  // Register and field widths
  localparam int STEP_W     = 16;
  localparam int EPS_W      = 10;
  localparam int HOLD_W     = 8;
  localparam int GAIN_W     = 10;
  localparam int FF_W       = 20;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = ((NUM_WHEELS * SPEED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_WHEELS * (SPEED_W + FF_W) + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_STEP = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DECEL_STEP = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_EPS   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TICKS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FF_GAIN    = 3'd4;

  // Register reset values
  localparam logic [STEP_W-1:0] ACCEL_RST = 16'd250;
  localparam logic [STEP_W-1:0] DECEL_RST = 16'd500;
  localparam logic [EPS_W-1:0]  EPS_RST   = 10'd1;
  localparam logic [HOLD_W-1:0] HOLD_RST  = 8'd4;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 10'd317;

  // Feedforward: ramp * gain / 25600, rounded half away from zero.
  // 25600 = 100 << 8: shift by 8, then divide by 100 through a reciprocal.
  localparam int PROD_W      = SPEED_W + GAIN_W;
  localparam int FF_SHIFT    = 8;
  localparam int FF_DIV_REST = 100;
  localparam int FF_HALF     = 12800;
  localparam int SCALED_W    = PROD_W + 1 - FF_SHIFT;
  localparam int RECIP_SHIFT = SCALED_W + 7;
  localparam int RECIP_W     = SCALED_W + 1;
  localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + FF_DIV_REST - 1) / FF_DIV_REST;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic [WHEEL_W-1:0]        wheel_t;

  // One wheel's stored state
  typedef struct packed {
    speed_t             cmd;
    speed_t             ramp;
    speed_t             pend;
    logic [HOLD_W-1:0]  hold;
    logic               rev;
  } wheel_state_t;

  localparam int STATE_W = $bits(wheel_state_t);

  // Issue stage to state read stage
  typedef struct packed {
    logic   vld;
    wheel_t wheel;
    logic   stop;
    speed_t tgt;
  } issue_t;

  // Target decision stage to slew stage
  typedef struct packed {
    logic                  vld;
    wheel_t                wheel;
    logic                  stop;
    wheel_state_t          st;
    speed_t                active;
    logic signed [SPEED_W:0] diff;
    logic [STEP_W-1:0]     step;
    logic                  cmd_small;
  } slew_t;

  // Per-wheel result travelling through the feedforward stages
  typedef struct packed {
    logic   vld;
    wheel_t wheel;
    speed_t ramp;
    logic   zeroed;
  } result_t;

  typedef struct packed {
    result_t           res;
    logic [PROD_W-1:0] prod;
  } ff_prod_t;

  typedef struct packed {
    result_t                      res;
    logic [SCALED_W+RECIP_W-1:0]  recip_prod;
  } ff_recip_t;

endpackage

`default_nettype wire

// ===== src/wheel_target_ramp_shaper.sv =====
// Top level of the wheel target ramp shaper: per-wheel slew limiter with
// reversal hold and feedforward. Depends on wtrs_pkg and wtrs_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_*  : one request per control tick. in_tdata carries the wheel targets,
//           in_tuser the stop flag.
//   out_* : one result per request: ramped targets and feedforward terms in
//           out_tdata, forced-zero flags in out_tuser.
//   cfg_* : register writes, taken at any edge with cfg_we high; write them
//           only while no request is in flight.
// Issue: a new request is taken at the earliest in the last issue slot of the one before.
//   Wheels go one per cycle, while the pipeline is not held, through a single
//   read-modify-write path on the wheel state RAM; an entry is written back from
//   the slew stage, and the issue slots per request leave room for that write.
// Path: a request goes from the accepting edge to out_tvalid through the input
//   register, RAM read, target decision, slew, two feedforward multiply stages
//   and result assembly.
// Reset: config, control and stage registers reset; every wheel entry reads as
//   zero through per-entry valid bits; no clearing pass, ready at once.
// Stall: the result register frees the input side, so a new request is taken
//   while a result waits. When the last wheel of the next request reaches
//   assembly with the result register still full, the whole pipeline holds.

module wheel_target_ramp_shaper (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: target_one, target_two, target_three
  input  wire logic [wtrs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: stop_all
  input  wire logic                                in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: ramp_one, ramp_two, ramp_three, ff_one, ff_two, ff_three, zero pad
  output logic [wtrs_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // out_tuser: zeroed_one, zeroed_two, zeroed_three
  output logic [wtrs_pkg::NUM_WHEELS-1:0]          out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_we,
  input  wire logic [wtrs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [wtrs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SW = wtrs_pkg::SPEED_W;
  localparam int NW = wtrs_pkg::NUM_WHEELS;

  typedef logic signed [SW+1:0] wide_t;

  function automatic logic [SW-1:0] mag(input wtrs_pkg::speed_t v);
    mag = v[SW-1] ? ((~v) + 1'b1) : v;
  endfunction

  function automatic wide_t sx(input wtrs_pkg::speed_t v);
    sx = {{2{v[SW-1]}}, v};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [wtrs_pkg::STEP_W-1:0] accel_step_r;
  logic [wtrs_pkg::STEP_W-1:0] decel_step_r;
  logic [wtrs_pkg::EPS_W-1:0]  zero_eps_r;
  logic [wtrs_pkg::HOLD_W-1:0] hold_ticks_r;
  logic [wtrs_pkg::GAIN_W-1:0] ff_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_step_r <= wtrs_pkg::ACCEL_RST;
      decel_step_r <= wtrs_pkg::DECEL_RST;
      zero_eps_r   <= wtrs_pkg::EPS_RST;
      hold_ticks_r <= wtrs_pkg::HOLD_RST;
      ff_gain_r    <= wtrs_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wtrs_pkg::CFG_ACCEL_STEP: accel_step_r <= cfg_wdata;
        wtrs_pkg::CFG_DECEL_STEP: decel_step_r <= cfg_wdata;
        wtrs_pkg::CFG_ZERO_EPS:   zero_eps_r   <= cfg_wdata[wtrs_pkg::EPS_W-1:0];
        wtrs_pkg::CFG_HOLD_TICKS: hold_ticks_r <= cfg_wdata[wtrs_pkg::HOLD_W-1:0];
        wtrs_pkg::CFG_FF_GAIN:    ff_gain_r    <= cfg_wdata[wtrs_pkg::GAIN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  logic [SW-1:0] eps;
  assign eps = SW'(zero_eps_r);

  // ---------------------------------------------------------------------------
  // Pipeline advance: hold everything when a finished result cannot leave
  // ---------------------------------------------------------------------------
  logic                    adv;
  logic                    asm_last;
  logic                    out_valid_r;
  wtrs_pkg::ff_recip_t     p5_r;

  assign asm_last = p5_r.res.vld &&
                    (p5_r.res.wheel == wtrs_pkg::WHEEL_W'(NW - 1));
  assign adv = !(asm_last && out_valid_r && !out_tready);

  // ---------------------------------------------------------------------------
  // Input register and issue slot counter
  // ---------------------------------------------------------------------------
  logic                         item_vld_r;
  logic                         item_stop_r;
  wtrs_pkg::speed_t             item_tgt_r [NW];
  logic [wtrs_pkg::SLOT_W-1:0]  slot_r;
  logic                         slot_end;
  logic                         issue_vld;
  wtrs_pkg::wheel_t             issue_wheel;

  assign slot_end    = (slot_r == wtrs_pkg::SLOT_W'(wtrs_pkg::ISSUE_CYCLES - 1));
  assign in_tready   = !item_vld_r || (adv && slot_end);
  assign issue_vld   = item_vld_r &&
                       ({1'b0, slot_r} < (wtrs_pkg::SLOT_W + 1)'(NW));
  assign issue_wheel = slot_r[wtrs_pkg::WHEEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      slot_r     <= '0;
    end else if (in_tvalid && in_tready) begin
      item_vld_r <= 1'b1;
      slot_r     <= '0;
    end else if (adv && item_vld_r) begin
      if (slot_end) begin
        item_vld_r <= 1'b0;
        slot_r     <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_stop_r <= in_tuser;
      for (int i = 0; i < NW; i++) begin
        item_tgt_r[i] <= in_tdata[i*SW +: SW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Wheel state RAM with per-entry valid bits (invalid reads as zero state)
  // ---------------------------------------------------------------------------
  logic                           ram_we;
  wtrs_pkg::wheel_t               ram_waddr;
  wtrs_pkg::wheel_state_t         ram_wdata;
  logic                           ram_re;
  logic [wtrs_pkg::STATE_W-1:0]   ram_rdata;
  logic [NW-1:0]                  entry_vld_r;
  logic                           rd_vld_r;

  assign ram_re = adv && issue_vld;

  wtrs_ram #(
    .WIDTH (wtrs_pkg::STATE_W),
    .DEPTH (NW)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_wheel),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (ram_we) begin
        entry_vld_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_r <= entry_vld_r[issue_wheel];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: issue one wheel
  // ---------------------------------------------------------------------------
  wtrs_pkg::issue_t p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
    end else if (adv) begin
      p1_r.vld   <= issue_vld;
      p1_r.wheel <= issue_wheel;
      p1_r.stop  <= item_stop_r;
      p1_r.tgt   <= item_tgt_r[issue_wheel];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: take the new target, pick the active target and the step
  // ---------------------------------------------------------------------------
  wtrs_pkg::wheel_state_t cur_st;
  wtrs_pkg::wheel_state_t dec_st;
  wtrs_pkg::speed_t       cur_ramp;
  wtrs_pkg::speed_t       tgt;
  wtrs_pkg::speed_t       active;
  logic [SW-1:0]          cur_mag;
  logic [SW-1:0]          tgt_mag;
  logic [SW-1:0]          act_mag;
  logic                   cur_big;
  logic                   tgt_big;
  logic                   act_big;
  logic                   opp_ct;
  logic                   opp_ca;
  logic                   accel;
  wtrs_pkg::slew_t        p2_r;

  always_comb begin
    cur_st   = rd_vld_r ? wtrs_pkg::wheel_state_t'(ram_rdata) : '0;
    cur_ramp = cur_st.ramp;
    tgt      = p1_r.tgt;
    cur_mag  = mag(cur_ramp);
    tgt_mag  = mag(tgt);
    cur_big  = cur_mag > eps;
    tgt_big  = tgt_mag > eps;
    opp_ct   = cur_big && tgt_big && (cur_ramp[SW-1] != tgt[SW-1]);

    dec_st = cur_st;
    if (cur_st.rev) begin
      dec_st.pend = tgt;
    end else if (opp_ct) begin
      // Start a reversal: ramp to zero, then hold
      dec_st.rev  = 1'b1;
      dec_st.pend = tgt;
      dec_st.hold = hold_ticks_r;
    end else begin
      dec_st.cmd = tgt;
    end

    active  = dec_st.rev ? '0 : dec_st.cmd;
    act_mag = mag(active);
    act_big = act_mag > eps;
    opp_ca  = cur_big && act_big && (cur_ramp[SW-1] != active[SW-1]);
    accel   = (!cur_big && act_big) || (!opp_ca && (act_mag > cur_mag));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_r <= '0;
    end else if (adv) begin
      p2_r.vld       <= p1_r.vld;
      p2_r.wheel     <= p1_r.wheel;
      p2_r.stop      <= p1_r.stop;
      p2_r.st        <= dec_st;
      p2_r.active    <= active;
      p2_r.diff      <= {active[SW-1], active} - {cur_ramp[SW-1], cur_ramp};
      p2_r.step      <= accel ? accel_step_r : decel_step_r;
      p2_r.cmd_small <= !(mag(dec_st.cmd) > eps);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: slew, forced zero, reversal hold; write the entry back
  // ---------------------------------------------------------------------------
  wtrs_pkg::speed_t       old_ramp;
  wtrs_pkg::speed_t       new_ramp;
  wide_t                  diff_w;
  wide_t                  step_w;
  wide_t                  cur_w;
  logic                   new_big;
  logic                   zeroed;
  wtrs_pkg::wheel_state_t upd_st;
  wtrs_pkg::result_t      p3_r;

  always_comb begin
    old_ramp = p2_r.st.ramp;
    cur_w    = sx(old_ramp);
    diff_w   = {p2_r.diff[SW], p2_r.diff};
    step_w   = {{(SW + 2 - wtrs_pkg::STEP_W){1'b0}}, p2_r.step};

    priority if (diff_w > step_w) begin
      new_ramp = SW'(cur_w + step_w);
    end else if (diff_w < -step_w) begin
      new_ramp = SW'(cur_w - step_w);
    end else begin
      new_ramp = p2_r.active;
    end
    new_big = mag(new_ramp) > eps;

    upd_st      = p2_r.st;
    upd_st.ramp = new_ramp;
    zeroed      = 1'b0;
    priority if (p2_r.stop) begin
      upd_st = '0;
      zeroed = 1'b1;
    end else if (p2_r.st.rev && !new_big) begin
      upd_st.ramp = '0;
      zeroed      = 1'b1;
      if (p2_r.st.hold != '0) begin
        upd_st.hold = p2_r.st.hold - 1'b1;
      end else begin
        // Hold done: take the latest target
        upd_st.rev = 1'b0;
        upd_st.cmd = p2_r.st.pend;
      end
    end else if (!p2_r.st.rev && p2_r.cmd_small && !new_big) begin
      upd_st.ramp = '0;
      zeroed      = 1'b1;
    end
  end

  assign ram_we    = adv && p2_r.vld;
  assign ram_waddr = p2_r.wheel;
  assign ram_wdata = upd_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_r <= '0;
    end else if (adv) begin
      p3_r.vld    <= p2_r.vld;
      p3_r.wheel  <= p2_r.wheel;
      p3_r.ramp   <= upd_st.ramp;
      p3_r.zeroed <= zeroed;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4-5: feedforward = |ramp| * gain / 25600 rounded, sign restored
  // ---------------------------------------------------------------------------
  wtrs_pkg::ff_prod_t                 p4_r;
  logic [wtrs_pkg::PROD_W:0]          rounded;
  logic [wtrs_pkg::SCALED_W-1:0]      scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_r <= '0;
    end else if (adv) begin
      p4_r.res  <= p3_r;
      p4_r.prod <= mag(p3_r.ramp) * ff_gain_r;
    end
  end

  assign rounded = {1'b0, p4_r.prod} + (wtrs_pkg::PROD_W + 1)'(wtrs_pkg::FF_HALF);
  assign scaled  = rounded[wtrs_pkg::PROD_W:wtrs_pkg::FF_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_r <= '0;
    end else if (adv) begin
      p5_r.res        <= p4_r.res;
      p5_r.recip_prod <= scaled * wtrs_pkg::RECIP;
    end
  end

  // ---------------------------------------------------------------------------
  // Result assembly and output register
  // ---------------------------------------------------------------------------
  logic [wtrs_pkg::FF_W-1:0]  ff_mag;
  logic [wtrs_pkg::FF_W-1:0]  ff_val;
  wtrs_pkg::speed_t           asm_ramp_r  [NW];
  logic [wtrs_pkg::FF_W-1:0]  asm_ff_r    [NW];
  logic [NW-1:0]              asm_zero_r;
  wtrs_pkg::speed_t           asm_ramp_nxt[NW];
  logic [wtrs_pkg::FF_W-1:0]  asm_ff_nxt  [NW];
  logic [NW-1:0]              asm_zero_nxt;
  logic [wtrs_pkg::OUT_TDATA_W-1:0] out_pack;
  logic [wtrs_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [NW-1:0]              out_tuser_r;

  assign ff_mag = wtrs_pkg::FF_W'(p5_r.recip_prod >> wtrs_pkg::RECIP_SHIFT);
  assign ff_val = p5_r.res.ramp[SW-1] ? ((~ff_mag) + 1'b1) : ff_mag;

  always_comb begin
    asm_ramp_nxt = asm_ramp_r;
    asm_ff_nxt   = asm_ff_r;
    asm_zero_nxt = asm_zero_r;
    if (p5_r.res.vld) begin
      asm_ramp_nxt[p5_r.res.wheel] = p5_r.res.ramp;
      asm_ff_nxt[p5_r.res.wheel]   = ff_val;
      asm_zero_nxt[p5_r.res.wheel] = p5_r.res.zeroed;
    end
    out_pack = '0;
    for (int i = 0; i < NW; i++) begin
      out_pack[i*SW +: SW]                             = asm_ramp_nxt[i];
      out_pack[NW*SW + i*wtrs_pkg::FF_W +: wtrs_pkg::FF_W] = asm_ff_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p5_r.res.vld) begin
      asm_ramp_r <= asm_ramp_nxt;
      asm_ff_r   <= asm_ff_nxt;
      asm_zero_r <= asm_zero_nxt;
    end
    if (adv && asm_last) begin
      out_tdata_r <= out_pack;
      out_tuser_r <= asm_zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && asm_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Issue spacing keeps a wheel's read clear of its own pending write
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && (ram_waddr == issue_wheel)))
    else $error("state RAM read and write hit the same wheel in one cycle");

  // A forced-zero first wheel shows zero ramp and zero feedforward
  a_zeroed_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r[0]) |->
      ((out_tdata_r[SW-1:0] == '0) && (out_tdata_r[NW*SW +: wtrs_pkg::FF_W] == '0)))
    else $error("zeroed wheel carries a nonzero ramp or feedforward");

  // A stop request clears the wheel and flags it zeroed
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && p2_r.vld && p2_r.stop) |=> (p3_r.zeroed && (p3_r.ramp == '0)))
    else $error("stop request left a wheel running");

  // A held pipeline keeps the wheel at the assembly stage
  a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p5_r))
    else $error("assembly stage moved while the pipeline was held");

endmodule

`default_nettype wire

// ===== src/wtrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module wtrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for wheel_target_ramp_shaper: directed and random control ticks.
// Builds expected ramps, zero flags and feedforward terms and compares every result.
// Depends on wtrs_pkg and the RTL under src/.
`timescale 1ns / 1ps

module testbench;
  import wtrs_pkg::*;

  // Index with no register behind it; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd5;
  // Feedforward divisor: 0.01 mm/s to mm/s times the Q2.8 gain scale
  localparam longint FF_DIVISOR = 25600;
  localparam int     FF_LSB     = NUM_WHEELS * SPEED_W;
  // Longest wait for outstanding results before they count as lost
  localparam int     DRAIN_LIMIT = 5000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [NUM_WHEELS-1:0]   out_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  wheel_target_ramp_shaper uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copy used by the predictor
  longint cfg_accel, cfg_decel, cfg_eps, cfg_hold, cfg_gain;

  // Per-wheel shaper state as the predictor sees it
  longint wheel_cmd  [NUM_WHEELS];
  longint wheel_ramp [NUM_WHEELS];
  longint wheel_pend [NUM_WHEELS];
  int     wheel_hold [NUM_WHEELS];
  bit     wheel_rev  [NUM_WHEELS];

  // Expected results, oldest first: packed out_tdata image and zero flags
  logic [OUT_TDATA_W-1:0]  shaped_tdata_q [$];
  logic [NUM_WHEELS-1:0]   shaped_zero_q  [$];

  // Random target runs per wheel
  longint run_tgt  [NUM_WHEELS];
  int     run_left [NUM_WHEELS];

  // Idling controls shared with the sink process
  bit feed_gaps;
  bit sink_stalls;
  bit hold_off_req;
  int hold_off_cycles;

  int errors;
  int requests_sent;
  int results_checked;
  int stop_ticks;
  int reversals;
  int settings_used;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // True when a and b lie outside the zero band on opposite sides
  function automatic bit opposite_dir(input longint a, input longint b);
    return (a > cfg_eps && b < -cfg_eps) || (a < -cfg_eps && b > cfg_eps);
  endfunction

  // One ramp step toward tgt; accel step only when the speed grows
  function automatic longint slew_toward(input longint cur, input longint tgt);
    bit     grow;
    longint stp;
    longint diff;
    grow = (magnitude(cur) <= cfg_eps && magnitude(tgt) > cfg_eps) ||
           (!opposite_dir(cur, tgt) && magnitude(tgt) > magnitude(cur));
    stp  = grow ? cfg_accel : cfg_decel;
    diff = tgt - cur;
    if (diff > stp)  return cur + stp;
    if (diff < -stp) return cur - stp;
    return tgt;
  endfunction

  // Ramp times gain over 25600, rounded half away from zero
  function automatic longint feedforward_mm(input longint r);
    longint q;
    q = (magnitude(r) * cfg_gain + FF_DIVISOR / 2) / FF_DIVISOR;
    return (r < 0) ? -q : q;
  endfunction

  task automatic clear_wheels;
    int w;
    for (w = 0; w < NUM_WHEELS; w++) begin
      wheel_cmd[w]  = 0;
      wheel_ramp[w] = 0;
      wheel_pend[w] = 0;
      wheel_hold[w] = 0;
      wheel_rev[w]  = 1'b0;
    end
  endtask

  // Advance every wheel by one tick and queue the result it must produce
  task automatic shape_tick(input logic [IN_TDATA_W-1:0] tgts, input logic stop);
    logic [OUT_TDATA_W-1:0] d;
    logic [NUM_WHEELS-1:0]  z;
    speed_t                 t;
    longint                 tgt, active, ff, r;
    int                     w;
    d = '0;
    z = '0;
    if (stop) begin
      // Stop wipes every wheel and forces all drives to zero
      clear_wheels();
      z = '1;
      stop_ticks++;
    end else begin
      for (w = 0; w < NUM_WHEELS; w++) begin
        t   = tgts[w*SPEED_W +: SPEED_W];
        tgt = t;
        ff  = 0;
        if (wheel_rev[w]) begin
          // Mid-reversal: remember only the latest target
          wheel_pend[w] = tgt;
        end else if (opposite_dir(wheel_ramp[w], tgt)) begin
          wheel_rev[w]  = 1'b1;
          wheel_pend[w] = tgt;
          wheel_hold[w] = cfg_hold;
          reversals++;
        end else begin
          wheel_cmd[w] = tgt;
        end
        active        = wheel_rev[w] ? 0 : wheel_cmd[w];
        wheel_ramp[w] = slew_toward(wheel_ramp[w], active);
        if (wheel_rev[w] && magnitude(wheel_ramp[w]) <= cfg_eps) begin
          // Parked at zero: count down the hold, then take the pending target
          wheel_ramp[w] = 0;
          z[w] = 1'b1;
          if (wheel_hold[w] > 0) begin
            wheel_hold[w]--;
          end else begin
            wheel_rev[w] = 1'b0;
            wheel_cmd[w] = wheel_pend[w];
          end
        end else if (!wheel_rev[w] && magnitude(wheel_cmd[w]) <= cfg_eps &&
                     magnitude(wheel_ramp[w]) <= cfg_eps) begin
          wheel_ramp[w] = 0;
          z[w] = 1'b1;
        end else begin
          ff = feedforward_mm(wheel_ramp[w]);
        end
        r = wheel_ramp[w];
        d[w*SPEED_W +: SPEED_W]     = r[SPEED_W-1:0];
        d[FF_LSB + w*FF_W +: FF_W] = ff[FF_W-1:0];
      end
    end
    shaped_tdata_q.push_back(d);
    shaped_zero_q.push_back(z);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    logic [OUT_TDATA_W-1:0] exp_d;
    logic [NUM_WHEELS-1:0]  exp_z;
    int                     w;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (shaped_tdata_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        exp_d = shaped_tdata_q.pop_front();
        exp_z = shaped_zero_q.pop_front();
        for (w = 0; w < NUM_WHEELS; w++) begin
          if (out_tdata[w*SPEED_W +: SPEED_W] !== exp_d[w*SPEED_W +: SPEED_W]) begin
            $display("%0t ns: ramp wheel %0d expected %0d, actual %0d", $time, w + 1,
                     $signed(exp_d[w*SPEED_W +: SPEED_W]),
                     $signed(out_tdata[w*SPEED_W +: SPEED_W]));
            errors++;
          end
          if (out_tdata[FF_LSB + w*FF_W +: FF_W] !== exp_d[FF_LSB + w*FF_W +: FF_W]) begin
            $display("%0t ns: ff wheel %0d expected %0d, actual %0d", $time, w + 1,
                     $signed(exp_d[FF_LSB + w*FF_W +: FF_W]),
                     $signed(out_tdata[FF_LSB + w*FF_W +: FF_W]));
            errors++;
          end
          if (out_tuser[w] !== exp_z[w]) begin
            $display("%0t ns: zeroed wheel %0d expected %b, actual %b", $time, w + 1,
                     exp_z[w], out_tuser[w]);
            errors++;
          end
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // Hold off long enough for the pipeline to fill and stall its input
        out_tready = 1'b0;
        for (hold_off_cycles = 0; hold_off_cycles < 400; hold_off_cycles++)
          @(negedge clk);
        hold_off_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one request; hold it until the handshake, then predict its result
  task automatic send_request(input logic [IN_TDATA_W-1:0] tgts, input logic stop);
    int gap;
    @(negedge clk);
    if (feed_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    in_tdata  = tgts;
    in_tuser  = stop;
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    shape_tick(tgts, stop);
    requests_sent++;
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_targets(input longint a, input longint b,
                                                          input longint c);
    logic [IN_TDATA_W-1:0] v;
    v = '0;
    v[0*SPEED_W +: SPEED_W] = a[SPEED_W-1:0];
    v[1*SPEED_W +: SPEED_W] = b[SPEED_W-1:0];
    v[2*SPEED_W +: SPEED_W] = c[SPEED_W-1:0];
    return v;
  endfunction

  // Drop valid and wait for every outstanding result, then let the pipe settle
  task automatic wait_idle;
    int waited;
    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (shaped_tdata_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (shaped_tdata_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, shaped_tdata_q.size());
      errors++;
      shaped_tdata_q.delete();
      shaped_zero_q.delete();
    end
    repeat (NUM_WHEELS + 8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      CFG_ACCEL_STEP: cfg_accel = val;
      CFG_DECEL_STEP: cfg_decel = val;
      CFG_ZERO_EPS:   cfg_eps   = val[EPS_W-1:0];
      CFG_HOLD_TICKS: cfg_hold  = val[HOLD_W-1:0];
      CFG_FF_GAIN:    cfg_gain  = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Load a full register setting once the block is idle
  task automatic set_regs(input int accel, input int decel, input int eps, input int hold,
                          input int gain);
    wait_idle();
    write_reg(CFG_ACCEL_STEP, accel);
    write_reg(CFG_DECEL_STEP, decel);
    write_reg(CFG_ZERO_EPS,   eps);
    write_reg(CFG_HOLD_TICKS, hold);
    write_reg(CFG_FF_GAIN,    gain);
    settings_used++;
  endtask

  // Targets for one random tick: each wheel keeps a target for a run of ticks,
  // so ramps get to settle, reverse and hold instead of chasing noise
  task automatic next_targets(output logic [IN_TDATA_W-1:0] tgts);
    longint scale, v;
    speed_t t;
    int     w, pick;
    scale = (cfg_accel + cfg_decel) * 24 + 64;
    if (scale > 4000000) scale = 4000000;
    for (w = 0; w < NUM_WHEELS; w++) begin
      if (run_left[w] == 0) begin
        run_left[w] = $urandom_range(1, 24);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // around the zero band
          v = longint'($urandom_range(0, 2 * cfg_eps + 6)) - cfg_eps - 3;
        end else if (pick < 55) begin
          v = longint'($urandom_range(0, 2 * scale)) - scale;
        end else if (pick < 72) begin
          // flip direction to start a reversal
          v = -run_tgt[w] + longint'($urandom_range(0, 20)) - 10;
        end else if (pick < 88) begin
          t = $urandom();
          v = t;
        end else begin
          case ($urandom_range(0, 2))
            0:       v = 8388607;
            1:       v = -8388608;
            default: v = 0;
          endcase
        end
        t = v[SPEED_W-1:0];
        run_tgt[w] = t;
      end
      run_left[w]--;
      v = run_tgt[w];
      tgts[w*SPEED_W +: SPEED_W] = v[SPEED_W-1:0];
    end
  endtask

  // Random ticks under the present setting; pause once midway for a full drain
  task automatic run_random(input int count, input bit idling);
    logic [IN_TDATA_W-1:0] tgts;
    logic                  stop;
    int                    k, pick;
    feed_gaps   = idling;
    sink_stalls = idling;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      next_targets(tgts);
      stop = 1'b0;
      if (pick < 5) begin
        // noise: unrelated bits on every wheel
        tgts = {$urandom(), $urandom(), $urandom()};
      end else if (pick < 7) begin
        stop = 1'b1;
      end
      send_request(tgts, stop);
      if (k == count / 2) wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: idle zero, full-scale ramps, zero band, reversal with hold, stop
  task automatic test_reset_values;
    int k;
    send_request(pack_targets(0, 0, 0), 1'b0);
    send_request(pack_targets(8388607, -8388608, 1), 1'b0);
    send_request(pack_targets(8388607, -8388608, 1), 1'b0);
    // Reverse wheels one and two; wheel three leaves zero toward a tiny target
    for (k = 0; k < 6; k++)
      send_request(pack_targets(-8388608, 8388607, -2), 1'b0);
    send_request(pack_targets(123, -456, 789), 1'b1);
    send_request(pack_targets(300, -300, 0), 1'b0);
  endtask

  // Largest steps, a zero band of 1000, no hold, largest gain
  task automatic test_register_extremes;
    set_regs(65535, 65535, 1000, 0, 1023);
    send_request(pack_targets(8388607, -8388608, 1000), 1'b0);
    send_request(pack_targets(1001, -1001, -1000), 1'b0);
    send_request(pack_targets(-8388608, 8388607, 0), 1'b0);
    send_request(pack_targets(8388607, -8388608, -1001), 1'b0);
  endtask

  // A zero step freezes the ramp; upper register bits and unmapped indexes drop
  task automatic test_zero_steps_and_masking;
    set_regs(0, 500, 1, 1, 317);
    send_request(pack_targets(5000, -5000, 0), 1'b0);
    send_request(pack_targets(8388607, -8388608, 3), 1'b0);
    set_regs(1000, 0, 1, 1, 317);
    send_request(pack_targets(0, 0, 0), 1'b0);
    send_request(pack_targets(-20000, 20000, 7), 1'b0);
    wait_idle();
    write_reg(CFG_DECEL_STEP, 16'hFFFF);
    write_reg(CFG_ZERO_EPS,   16'hFC05);
    write_reg(CFG_HOLD_TICKS, 16'hFF03);
    write_reg(CFG_FF_GAIN,    16'h8123);
    write_reg(CFG_UNMAPPED,   16'h0001);
    settings_used++;
    send_request(pack_targets(4, -6, 40000), 1'b0);
    send_request(pack_targets(-9000, 9000, 40000), 1'b0);
  endtask

  // Sink holds off while requests keep coming, so the block must stall its input
  task automatic test_backpressure;
    logic [IN_TDATA_W-1:0] tgts;
    int                    k;
    set_regs(3000, 4000, 2, 3, 600);
    feed_gaps    = 1'b0;
    hold_off_req = 1'b1;
    for (k = 0; k < 40; k++) begin
      next_targets(tgts);
      send_request(tgts, 1'b0);
    end
    wait_idle();
  endtask

  // Random ticks across several settings, extremes among them
  task automatic test_random_settings;
    set_regs(ACCEL_RST, DECEL_RST, EPS_RST, HOLD_RST, GAIN_RST);
    run_random(350, 1'b1);
    set_regs(2000, 5000, 0, 0, 1023);
    run_random(350, 1'b1);
    set_regs(1, 65535, 1000, 255, 0);
    run_random(250, 1'b1);
    set_regs(65535, 1, 37, 2, 512);
    run_random(300, 1'b1);
    set_regs(700, 1200, 12, 9, 200);
    run_random(150, 1'b1);
  endtask

  // Closing stretch at full rate: no source gaps, no sink stalls
  task automatic test_full_rate;
    set_regs(3000, 3000, 3, 1, 400);
    run_random(200, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    in_tvalid    = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    feed_gaps    = 1'b1;
    sink_stalls  = 1'b1;
    hold_off_req = 1'b0;
    errors          = 0;
    requests_sent   = 0;
    results_checked = 0;
    stop_ticks      = 0;
    reversals       = 0;
    settings_used   = 1;
    cfg_accel = ACCEL_RST;
    cfg_decel = DECEL_RST;
    cfg_eps   = EPS_RST;
    cfg_hold  = HOLD_RST;
    cfg_gain  = GAIN_RST;
    clear_wheels();
    for (int w = 0; w < NUM_WHEELS; w++) begin
      run_tgt[w]  = 0;
      run_left[w] = 0;
    end

    // Hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_register_extremes();
    test_zero_steps_and_masking();
    test_backpressure();
    test_random_settings();
    test_full_rate();

    // Drain, then give stray results a chance to show up
    wait_idle();
    repeat (4 * (NUM_WHEELS + 5)) @(posedge clk);

    $display("covered %0d requests, %0d stop ticks, %0d direction reversals",
             requests_sent, stop_ticks, reversals);
    $display("checked %0d results over %0d register settings", results_checked,
             settings_used);
    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // Hard limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
